[hdl/triangle_refine_point_matrix_unit_assert.svh]
// Assertion macros for the triangle refine point matrix unit.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef TRIANGLE_REFINE_POINT_MATRIX_UNIT_ASSERT_SVH
`define TRIANGLE_REFINE_POINT_MATRIX_UNIT_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define TRPM_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TRPM_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/trpm_pkg.sv]
// ----------------------------------------------------------------------------
// trpm_pkg
// Types, group codes and midpoint helpers shared by the refine point matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package trpm_pkg;

	localparam int unsigned CODE_W  = 36;
	localparam int unsigned GROUP_W = 3;
	localparam int unsigned COORD_W = 13;
	localparam int unsigned FRAC_W  = 12;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [GROUP_W-1:0] group_t;
	typedef logic [COORD_W-1:0] coord_t;

	// 1.0 in fixed point
	localparam coord_t ONE_FX = coord_t'(1 << FRAC_W);

	// Refinement group codes
	localparam group_t GRP_NONE    = 3'd0;
	localparam group_t GRP_CHILD0  = 3'd1;
	localparam group_t GRP_CHILD1  = 3'd2;
	localparam group_t GRP_CHILD2  = 3'd3;
	localparam group_t GRP_CHILD3  = 3'd4;
	localparam group_t GRP_BISECT0 = 3'd5;
	localparam group_t GRP_BISECT1 = 3'd6;
	localparam group_t GRP_BAD     = 3'd7;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t a;
		point_t b;
		point_t c;
	} vtx_t;

	// Item state carried from one level stage to the next
	typedef struct packed {
		vtx_t  verts;
		code_t code;
		logic  started;
		logic  bad;
	} stage_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t b_x;
		coord_t b_y;
		coord_t c_x;
		coord_t c_y;
		logic   invalid;
	} result_t;

	localparam vtx_t UNIT_VERTS = '{
		a: '{x: '0,     y: '0},
		b: '{x: ONE_FX, y: '0},
		c: '{x: '0,     y: ONE_FX}
	};

	function automatic coord_t mid_coord(coord_t p, coord_t q);
		logic [COORD_W:0] sum;
		begin
			sum = {1'b0, p} + {1'b0, q};
			return sum[COORD_W:1];
		end
	endfunction

	function automatic point_t mid(point_t p, point_t q);
		point_t r;
		begin
			r.x = mid_coord(p.x, q.x);
			r.y = mid_coord(p.y, q.y);
			return r;
		end
	endfunction

	// Apply one refinement group; invalid codes leave the vertices alone.
	function automatic vtx_t refine(vtx_t v, group_t g);
		vtx_t r;
		begin
			r = v;
			unique case (g)
				GRP_CHILD0: begin
					r.b = mid(v.a, v.b);
					r.c = mid(v.a, v.c);
				end
				GRP_CHILD1: begin
					r.a = mid(v.a, v.b);
					r.c = mid(v.b, v.c);
				end
				GRP_CHILD2: begin
					r.a = mid(v.a, v.c);
					r.b = mid(v.b, v.c);
				end
				GRP_CHILD3: begin
					r.a = mid(v.b, v.c);
					r.b = mid(v.c, v.a);
					r.c = mid(v.a, v.b);
				end
				GRP_BISECT0: begin
					r.a = v.c;
					r.b = v.a;
					r.c = mid(v.a, v.b);
				end
				GRP_BISECT1: begin
					r.a = v.b;
					r.b = v.c;
					r.c = mid(v.a, v.b);
				end
				default: begin
					r = v;
				end
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

[hdl/trpm_stream_if.sv]
// ----------------------------------------------------------------------------
// trpm_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface trpm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/trpm_level.sv]
// ----------------------------------------------------------------------------
// trpm_level
// One pipeline stage: apply the refinement group of one level and register.
// ----------------------------------------------------------------------------
`default_nettype none

module trpm_level #(
	parameter int unsigned LEVEL = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire trpm_pkg::stage_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output trpm_pkg::stage_t     out_data
);
	import trpm_pkg::*;

	localparam bit HAS_GROUP = ((LEVEL + 1) * GROUP_W) <= CODE_W;

	group_t grp;
	logic   start_now;
	logic   grp_bad;
	stage_t next_d;
	logic   valid_s1;
	stage_t data_s1;

	generate
		if (HAS_GROUP) begin : g_group
			assign grp = in_data.code[LEVEL*GROUP_W +: GROUP_W];
		end else begin : g_nogroup
			// levels above the code width read as zero groups
			assign grp = GRP_NONE;
		end
	endgenerate

	assign start_now = in_data.started || (grp != GRP_NONE);
	assign grp_bad   = (grp == GRP_NONE) || (grp == GRP_BAD);

	always_comb begin
		next_d = in_data;
		if (start_now) begin
			next_d.started = 1'b1;
			next_d.bad     = in_data.bad || grp_bad;
			next_d.verts   = refine(in_data.verts, grp);
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_d;
		end
	end

endmodule

`default_nettype wire

[hdl/triangle_refine_point_matrix_unit.sv]
// ----------------------------------------------------------------------------
// triangle_refine_point_matrix_unit
// Turns a packed refinement code into the vertices of one child triangle.
// ----------------------------------------------------------------------------
// Each item on codes is a chain of 3-bit groups; group 0 is the lowest three
// bits and is applied last. Starting from the unit triangle a=(0,0), b=(1,0),
// c=(0,1), the groups are applied from the highest nonzero group downward:
// values 1 to 4 pick one of the four uniform children, 5 and 6 pick one of the
// two bisection children, and every new vertex is the midpoint of two others.
// Coordinates leave on coords as unsigned fixed point with 12 fraction bits
// (4096 is 1.0). A group of 7, or a zero group below a nonzero one, raises
// invalid and forces all coordinates to zero. A zero code gives the unit
// triangle. Only the low 3*MAX_LEVELS bits of the code are looked at.
// The pipeline has one register stage per level, and a new item is taken every
// cycle as long as coords is drained. Backpressure passes back combinationally
// through full stages; empty stages fill while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_refine_point_matrix_unit_assert.svh"

module triangle_refine_point_matrix_unit #(
	parameter int unsigned MAX_LEVELS = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	trpm_stream_if.sink   codes,
	trpm_stream_if.source coords
);
	import trpm_pkg::*;

	// Link i feeds stage i; link MAX_LEVELS is the stage chain's output.
	logic   link_valid [0:MAX_LEVELS];
	logic   link_ready [0:MAX_LEVELS];
	stage_t link_data  [0:MAX_LEVELS];
	stage_t last;

	// Seed each item with the unit triangle before any group is applied.
	assign link_valid[0]       = codes.valid;
	assign codes.ready         = link_ready[0];
	assign link_data[0].verts   = UNIT_VERTS;
	assign link_data[0].code    = codes.payload;
	assign link_data[0].started = 1'b0;
	assign link_data[0].bad     = 1'b0;

	// Stage i handles the level MAX_LEVELS-1-i, highest level first.
	genvar i;
	generate
		for (i = 0; i < MAX_LEVELS; i++) begin : g_lvl
			trpm_level #(
				.LEVEL(MAX_LEVELS - 1 - i)
			) u_level (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (link_valid[i]),
				.in_ready (link_ready[i]),
				.in_data  (link_data[i]),
				.out_valid(link_valid[i+1]),
				.out_ready(link_ready[i+1]),
				.out_data (link_data[i+1])
			);
		end
	endgenerate

	assign last                   = link_data[MAX_LEVELS];
	assign coords.valid           = link_valid[MAX_LEVELS];
	assign link_ready[MAX_LEVELS] = coords.ready;

	// Drop all coordinates of a malformed chain to zero.
	assign coords.payload.a_x     = last.bad ? '0 : last.verts.a.x;
	assign coords.payload.a_y     = last.bad ? '0 : last.verts.a.y;
	assign coords.payload.b_x     = last.bad ? '0 : last.verts.b.x;
	assign coords.payload.b_y     = last.bad ? '0 : last.verts.b.y;
	assign coords.payload.c_x     = last.bad ? '0 : last.verts.c.x;
	assign coords.payload.c_y     = last.bad ? '0 : last.verts.c.y;
	assign coords.payload.invalid = last.bad;

	// Midpoints never leave the unit square.
	`TRPM_ASSERT_IMPLY(a_coord_range, clk, arst_n, coords.valid,
		(coords.payload.a_x <= ONE_FX) && (coords.payload.a_y <= ONE_FX) &&
		(coords.payload.b_x <= ONE_FX) && (coords.payload.b_y <= ONE_FX) &&
		(coords.payload.c_x <= ONE_FX) && (coords.payload.c_y <= ONE_FX),
		"coordinate above 1.0")

	// A chain with no applied group comes out as a clean unit triangle.
	`TRPM_ASSERT_IMPLY(a_unstarted_unit, clk, arst_n, coords.valid && !last.started,
		(last.verts == UNIT_VERTS) && !last.bad,
		"unstarted item altered")

	// The input only stalls when a finished item is waiting at the output.
	`TRPM_ASSERT_IMPLY(a_stall_source, clk, arst_n, !codes.ready,
		coords.valid && !coords.ready,
		"input stalled without output backpressure")

endmodule

`default_nettype wire
